// ===== design/bbox_pkg.sv =====
// Shared types and constants for the black border bounding box block.
`default_nettype none

package bbox_pkg;

  localparam int unsigned SizeWidth  = 13;
  localparam int unsigned LumaWidth  = 8;
  localparam int unsigned CoordWidth = 12;

  localparam logic [LumaWidth-1:0] DEFAULT_BLACK_LEVEL = 8'd24;
  localparam logic [SizeWidth-1:0] RESET_FRAME_SIZE    = 13'd4096;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BLACK_LEVEL  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SizeWidth-1:0] width;
    logic [SizeWidth-1:0] height;
    logic [LumaWidth-1:0] threshold;
  } frame_cfg_t;

  typedef struct packed {
    logic                  has_video;
    logic [CoordWidth-1:0] left;
    logic [CoordWidth-1:0] top;
    logic [SizeWidth-1:0]  width;
    logic [SizeWidth-1:0]  height;
  } box_t;

endpackage

`default_nettype wire

// ===== design/bbox_cfg.sv =====
// Configuration registers and effective frame size and threshold.
`default_nettype none

module bbox_cfg #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire bbox_pkg::cfg_reg_t             cfg_index,
  input  wire logic [bbox_pkg::SizeWidth-1:0] cfg_data,
  output bbox_pkg::frame_cfg_t                frame_cfg
);

  logic [bbox_pkg::SizeWidth-1:0] frame_width_r;
  logic [bbox_pkg::SizeWidth-1:0] frame_height_r;
  logic [bbox_pkg::LumaWidth-1:0] black_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbox_pkg::RESET_FRAME_SIZE;
      frame_height_r <= bbox_pkg::RESET_FRAME_SIZE;
      black_level_r  <= bbox_pkg::DEFAULT_BLACK_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        bbox_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        bbox_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        bbox_pkg::REG_BLACK_LEVEL:  black_level_r  <= cfg_data[bbox_pkg::LumaWidth-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to 1..MAX, substitute the default threshold for zero
  always_comb begin
    if (frame_width_r == '0) begin
      frame_cfg.width = bbox_pkg::SizeWidth'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      frame_cfg.width = bbox_pkg::SizeWidth'(MAX_WIDTH);
    end else begin
      frame_cfg.width = frame_width_r;
    end
    if (frame_height_r == '0) begin
      frame_cfg.height = bbox_pkg::SizeWidth'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      frame_cfg.height = bbox_pkg::SizeWidth'(MAX_HEIGHT);
    end else begin
      frame_cfg.height = frame_height_r;
    end
    frame_cfg.threshold = (black_level_r == '0) ? bbox_pkg::DEFAULT_BLACK_LEVEL
                                                : black_level_r;
  end

endmodule

`default_nettype wire

// ===== design/bbox_tracker.sv =====
// Column and row counters, video extent tracking and crop box result.
`default_nettype none

module bbox_tracker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire logic [bbox_pkg::LumaWidth-1:0] luma,
  input  wire bbox_pkg::frame_cfg_t           frame_cfg,
  output logic                                frame_end,
  output bbox_pkg::box_t                      box
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [RW-1:0] top_row_r, top_row_nxt, top_row_upd;
  logic [RW-1:0] bottom_row_r, bottom_row_nxt, bottom_row_upd;
  logic [CW-1:0] min_col_r, min_col_nxt, min_col_upd;
  logic [CW-1:0] max_col_r, max_col_nxt, max_col_upd;
  logic          seen_video_r, seen_video_nxt, seen_video_upd;
  logic          video;
  logic          last_col;
  logic          last_row;

  always_comb begin
    video    = luma > frame_cfg.threshold;
    last_col = (32'(col_count_r) + 32'd1) >= 32'(frame_cfg.width);
    last_row = (32'(row_count_r) + 32'd1) >= 32'(frame_cfg.height);
    frame_end = last_col && last_row;

    top_row_upd    = top_row_r;
    bottom_row_upd = bottom_row_r;
    min_col_upd    = min_col_r;
    max_col_upd    = max_col_r;
    seen_video_upd = seen_video_r;
    if (video) begin
      if (!seen_video_r) begin
        top_row_upd = row_count_r;
      end
      bottom_row_upd = row_count_r;
      if (!seen_video_r || col_count_r < min_col_r) begin
        min_col_upd = col_count_r;
      end
      if (!seen_video_r || col_count_r > max_col_r) begin
        max_col_upd = col_count_r;
      end
      seen_video_upd = 1'b1;
    end

    if (seen_video_upd) begin
      box.has_video = 1'b1;
      box.left      = bbox_pkg::CoordWidth'(32'(min_col_upd));
      box.top       = bbox_pkg::CoordWidth'(32'(top_row_upd));
      box.width     = bbox_pkg::SizeWidth'(32'(max_col_upd) - 32'(min_col_upd) + 32'd1);
      box.height    = bbox_pkg::SizeWidth'(32'(bottom_row_upd) - 32'(top_row_upd) + 32'd1);
    end else begin
      box = '0;
    end

    if (frame_end) begin
      col_count_nxt  = '0;
      row_count_nxt  = '0;
      top_row_nxt    = '0;
      bottom_row_nxt = '0;
      min_col_nxt    = CW'(MAX_WIDTH - 1);
      max_col_nxt    = '0;
      seen_video_nxt = 1'b0;
    end else begin
      top_row_nxt    = top_row_upd;
      bottom_row_nxt = bottom_row_upd;
      min_col_nxt    = min_col_upd;
      max_col_nxt    = max_col_upd;
      seen_video_nxt = seen_video_upd;
      if (last_col) begin
        col_count_nxt = '0;
        row_count_nxt = row_count_r + RW'(1);
      end else begin
        col_count_nxt = col_count_r + CW'(1);
        row_count_nxt = row_count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r  <= '0;
      row_count_r  <= '0;
      top_row_r    <= '0;
      bottom_row_r <= '0;
      min_col_r    <= CW'(MAX_WIDTH - 1);
      max_col_r    <= '0;
      seen_video_r <= 1'b0;
    end else if (advance) begin
      col_count_r  <= col_count_nxt;
      row_count_r  <= row_count_nxt;
      top_row_r    <= top_row_nxt;
      bottom_row_r <= bottom_row_nxt;
      min_col_r    <= min_col_nxt;
      max_col_r    <= max_col_nxt;
      seen_video_r <= seen_video_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/black_border_bounding_box.sv =====
// Top level of the black border bounding box (letterbox crop detect) block.
// Usage:
//   Input channel in_valid/in_ready/in_luma carries one luma word per pixel in
//   raster order; the block counts column and row itself against frame_width
//   and frame_height. Result channel out_valid/out_ready carries one word per
//   frame, issued on the last pixel: has_video and the crop box
//   (left, top, width, height), all zero when the frame is wholly black.
//   Configuration: cfg_we with cfg_index (0 width, 1 height, 2 black level)
//   and cfg_data; write only while no pixel is in flight.
//   Path: a pixel is held in the input register, and the result of a frame's
//   last pixel is loaded into the output register as that pixel advances, so
//   out_valid rises in the cycle after that advance.
//   Throughput: one pixel per cycle unless a frame-ending pixel stalls, set by
//   the single tracker update between the input and result registers.
//   Stall: while the output register holds an untaken result, pixels that do
//   not end a frame still advance; a frame-ending pixel waits in the input
//   register, and in_ready drops only then.
//   Reset: width, height 4096, black level 24, counters and extents cleared.
`default_nettype none

module black_border_bounding_box #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bbox_pkg::LumaWidth-1:0]  in_luma,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_has_video,
  output logic [bbox_pkg::CoordWidth-1:0]      out_box_left,
  output logic [bbox_pkg::CoordWidth-1:0]      out_box_top,
  output logic [bbox_pkg::SizeWidth-1:0]       out_box_width,
  output logic [bbox_pkg::SizeWidth-1:0]       out_box_height,
  input  wire logic                            cfg_we,
  input  wire bbox_pkg::cfg_reg_t              cfg_index,
  input  wire logic [bbox_pkg::SizeWidth-1:0]  cfg_data
);

  bbox_pkg::frame_cfg_t           frame_cfg;
  bbox_pkg::box_t                 box;
  bbox_pkg::box_t                 box_r;
  logic                           frame_end;
  logic                           advance;
  logic                           in_valid_r, in_valid_nxt;
  logic [bbox_pkg::LumaWidth-1:0] in_luma_r;
  logic                           out_valid_r, out_valid_nxt;

  bbox_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame_cfg (frame_cfg)
  );

  bbox_tracker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .luma      (in_luma_r),
    .frame_cfg (frame_cfg),
    .frame_end (frame_end),
    .box       (box)
  );

  always_comb begin
    advance  = in_valid_r && (!frame_end || !out_valid_r || out_ready);
    in_ready = !in_valid_r || advance;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
    if (advance && frame_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_luma_r <= in_luma;
    end
    if (advance && frame_end) begin
      box_r <= box;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_video  = box_r.has_video;
  assign out_box_left   = box_r.left;
  assign out_box_top    = box_r.top;
  assign out_box_width  = box_r.width;
  assign out_box_height = box_r.height;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance && frame_end |=> out_valid_r)
    else $error("frame end did not load the result register");

  a_pixel_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && frame_end && out_valid_r && !out_ready |=>
      in_valid_r && $stable(in_luma_r))
    else $error("frame-ending pixel lost while the result stalled");

  a_black_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !box_r.has_video |->
      box_r.left == '0 && box_r.top == '0 && box_r.width == '0 && box_r.height == '0)
    else $error("black frame reported a non-zero box");

endmodule

`default_nettype wire
